### rtl/display_area_scroll_address_gen_defines.svh
// ---------------------------------------------------------------------------
// Display area scroll address generator: assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ---------------------------------------------------------------------------
`ifndef DISPLAY_AREA_SCROLL_ADDRESS_GEN_DEFINES_SVH
`define DISPLAY_AREA_SCROLL_ADDRESS_GEN_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DASAG_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dasag: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define DASAG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dasag: next-cycle check failed");

`endif

### rtl/dasag_pkg.sv
// ---------------------------------------------------------------------------
// Display area scroll address generator package
// Register map, reset values, field positions and shared types.
// ---------------------------------------------------------------------------
package dasag_pkg;

  localparam int unsigned AddrBitsDef = 15;

  localparam int unsigned LineBits   = 10;
  localparam int unsigned StartBits  = 15;
  localparam int unsigned RepeatBits = 6;
  localparam int unsigned PitchBits  = 8;
  localparam int unsigned CtrlBits   = 10;
  localparam int unsigned NumAreas   = 4;
  localparam int unsigned PaddrBits  = 5;

  localparam logic [2:0] RegArea0     = 3'd0;
  localparam logic [2:0] RegArea1     = 3'd1;
  localparam logic [2:0] RegArea2     = 3'd2;
  localparam logic [2:0] RegArea3     = 3'd3;
  localparam logic [2:0] RegControl   = 3'd4;
  localparam logic [2:0] RegRepeat    = 3'd5;
  localparam logic [2:0] RegFirstLine = 3'd6;
  localparam logic [2:0] RegEndLine   = 3'd7;

  localparam logic [CtrlBits-1:0]   CtrlReset      = 10'd80;
  localparam logic [RepeatBits-1:0] RepeatReset    = 6'd1;
  localparam logic [LineBits-1:0]   FirstLineReset = 10'd0;
  localparam logic [LineBits-1:0]   EndLineReset   = 10'd400;

  localparam int unsigned CtrlOddSkipBit  = 8;
  localparam int unsigned CtrlTwoAreaBit  = 9;
  localparam int unsigned AreaPitchKeepBit = 30;

  typedef struct packed {
    logic [NumAreas-1:0][31:0] area_word;
    logic [CtrlBits-1:0]       control_bits;
    logic [RepeatBits-1:0]     line_repeat;
    logic [LineBits-1:0]       first_line;
    logic [LineBits-1:0]       end_line;
  } cfg_t;

  typedef struct packed {
    logic                  frame_last;
    logic                  draw_line;
    logic [StartBits-1:0]  start_address;
    logic [LineBits-1:0]   line_number;
  } result_t;

endpackage

### rtl/display_area_scroll_address_gen.sv
// ---------------------------------------------------------------------------
// Display area scroll address generator
// Per-line scan address generation over up to four scroll areas.
// ---------------------------------------------------------------------------
// Each input word is one raster-line tick, or a frame restart when bit 0 is
// set, and yields at most one result word: the line number, the fetch start
// address, a draw flag in tuser and the frame's final line marked by tlast.
// Ticks that arrive while no frame is running give no result. One word is
// taken in every cycle while the skid stage is empty; the result is held in
// the output register, or in the skid register while the output is stalled,
// and updating the line, area and address counters per accepted word sets that
// rate. A skid stage lets the input keep flowing for one word while the output
// is stalled. Configuration must be written only while no frame work is outstanding.
// ---------------------------------------------------------------------------
`include "display_area_scroll_address_gen_defines.svh"

module display_area_scroll_address_gen #(
  parameter int unsigned ADDR_BITS = dasag_pkg::AddrBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dasag_pkg::PaddrBits-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // Bit 0 restart, bits 7:1 zero.
  input  logic [7:0]                      s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // Bits 9:0 line_number, bits 24:10 start_address, bits 31:25 zero.
  output logic [31:0]                     m_axis_tdata,
  // Bit 0 draw_line.
  output logic [0:0]                      m_axis_tuser,
  output logic                            m_axis_tlast
);

  dasag_pkg::cfg_t    cfg;
  dasag_pkg::result_t res;
  dasag_pkg::result_t out_res;
  logic               res_valid;

  dasag_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dasag_engine #(
    .ADDR_BITS (ADDR_BITS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_i  (s_axis_tready),
    .restart_i   (s_axis_tdata[0]),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  dasag_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (res_valid),
    .in_data_i   (res),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (out_res),
    .out_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {7'd0, out_res.start_address, out_res.line_number};
  assign m_axis_tuser = out_res.draw_line;
  assign m_axis_tlast = out_res.frame_last;

  `DASAG_ASSERT_SAME(a_skid_full_implies_out, !s_axis_tready, m_axis_tvalid)
  `DASAG_ASSERT_NEXT(a_restart_gives_word, s_axis_tvalid && s_axis_tready && s_axis_tdata[0], m_axis_tvalid)
  `DASAG_ASSERT_SAME(a_skip_only_odd, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[0])

endmodule

### rtl/dasag_regs.sv
// ---------------------------------------------------------------------------
// Display area scroll address generator configuration registers
// APB-style register file holding the area words and frame controls.
// ---------------------------------------------------------------------------
module dasag_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dasag_pkg::PaddrBits-1:0]   paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  output dasag_pkg::cfg_t                   cfg_o
);

  dasag_pkg::cfg_t cfg_q, cfg_d;
  logic [2:0]      reg_idx;
  logic            wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        dasag_pkg::RegArea0:     cfg_d.area_word[0] = pwdata;
        dasag_pkg::RegArea1:     cfg_d.area_word[1] = pwdata;
        dasag_pkg::RegArea2:     cfg_d.area_word[2] = pwdata;
        dasag_pkg::RegArea3:     cfg_d.area_word[3] = pwdata;
        dasag_pkg::RegControl:   cfg_d.control_bits = pwdata[dasag_pkg::CtrlBits-1:0];
        dasag_pkg::RegRepeat:    cfg_d.line_repeat  = pwdata[dasag_pkg::RepeatBits-1:0];
        dasag_pkg::RegFirstLine: cfg_d.first_line   = pwdata[dasag_pkg::LineBits-1:0];
        dasag_pkg::RegEndLine:   cfg_d.end_line     = pwdata[dasag_pkg::LineBits-1:0];
        default:                 cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      dasag_pkg::RegArea0:     prdata = cfg_q.area_word[0];
      dasag_pkg::RegArea1:     prdata = cfg_q.area_word[1];
      dasag_pkg::RegArea2:     prdata = cfg_q.area_word[2];
      dasag_pkg::RegArea3:     prdata = cfg_q.area_word[3];
      dasag_pkg::RegControl:   prdata = 32'(cfg_q.control_bits);
      dasag_pkg::RegRepeat:    prdata = 32'(cfg_q.line_repeat);
      dasag_pkg::RegFirstLine: prdata = 32'(cfg_q.first_line);
      dasag_pkg::RegEndLine:   prdata = 32'(cfg_q.end_line);
      default:                 prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.area_word    <= '0;
      cfg_q.control_bits <= dasag_pkg::CtrlReset;
      cfg_q.line_repeat  <= dasag_pkg::RepeatReset;
      cfg_q.first_line   <= dasag_pkg::FirstLineReset;
      cfg_q.end_line     <= dasag_pkg::EndLineReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### rtl/dasag_engine.sv
// ---------------------------------------------------------------------------
// Display area scroll address generator line engine
// Holds the scan state and works out one line's result per accepted word while a frame runs or restarts.
// ---------------------------------------------------------------------------
module dasag_engine #(
  parameter int unsigned ADDR_BITS = dasag_pkg::AddrBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dasag_pkg::cfg_t   cfg_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic              restart_i,
  output logic              res_valid_o,
  output dasag_pkg::result_t res_o
);

  localparam int unsigned LB = dasag_pkg::LineBits;
  localparam int unsigned RB = dasag_pkg::RepeatBits;
  localparam int unsigned PB = dasag_pkg::PitchBits;

  function automatic logic [ADDR_BITS-1:0] area_addr(input logic [31:0] word);
    logic [31:0] shifted;
    shifted = {15'd0, word[15:0], 1'b0};
    return shifted[ADDR_BITS-1:0];
  endfunction

  function automatic logic [PB-1:0] area_pitch(input logic [31:0] word,
                                               input logic [7:0]  pitch);
    logic [PB-1:0] p;
    if (word[dasag_pkg::AreaPitchKeepBit]) begin
      p = {pitch[7:1], 1'b0};
    end else begin
      p = {pitch[6:0], 1'b0};
    end
    return p;
  endfunction

  logic [1:0]           area_q, area_d;
  logic [LB-1:0]        left_q, left_d;
  logic [RB-1:0]        rep_q, rep_d;
  logic [ADDR_BITS-1:0] addr_q, addr_d;
  logic [PB-1:0]        pitch_q, pitch_d;
  logic [LB-1:0]        line_q, line_d;
  logic                 done_q, done_d;

  logic [1:0]           eff_area;
  logic [LB-1:0]        eff_left;
  logic [RB-1:0]        eff_rep;
  logic [ADDR_BITS-1:0] eff_addr;
  logic [PB-1:0]        eff_pitch;
  logic [LB-1:0]        eff_line;

  logic                 accept;
  logic                 emit;
  logic                 last;
  logic [LB:0]          line_inc;
  logic [LB-1:0]        left_dec;
  logic [RB-1:0]        rep_dec;
  logic [1:0]           next_area;
  logic [31:0]          next_word;
  logic [31:0]          addr_ext;

  assign accept = in_valid_i && in_ready_i;
  assign emit   = restart_i || !done_q;

  always_comb begin
    if (restart_i) begin
      eff_area  = 2'd0;
      eff_left  = cfg_i.area_word[0][29:20];
      eff_rep   = cfg_i.line_repeat;
      eff_addr  = area_addr(cfg_i.area_word[0]);
      eff_pitch = area_pitch(cfg_i.area_word[0], cfg_i.control_bits[7:0]);
      eff_line  = cfg_i.first_line;
    end else begin
      eff_area  = area_q;
      eff_left  = left_q;
      eff_rep   = rep_q;
      eff_addr  = addr_q;
      eff_pitch = pitch_q;
      eff_line  = line_q;
    end
  end

  assign line_inc  = {1'b0, eff_line} + (LB+1)'(1);
  assign last      = line_inc >= {1'b0, cfg_i.end_line};
  assign left_dec  = eff_left - LB'(1);
  assign rep_dec   = eff_rep - RB'(1);
  assign next_area = cfg_i.control_bits[dasag_pkg::CtrlTwoAreaBit]
                     ? ((eff_area == 2'd0) ? 2'd1 : 2'd0)
                     : eff_area + 2'd1;
  assign next_word = cfg_i.area_word[next_area];

  always_comb begin
    area_d  = area_q;
    left_d  = left_q;
    rep_d   = rep_q;
    addr_d  = addr_q;
    pitch_d = pitch_q;
    line_d  = line_q;
    done_d  = done_q;
    if (accept && emit) begin
      area_d  = eff_area;
      left_d  = eff_left;
      rep_d   = eff_rep;
      addr_d  = eff_addr;
      pitch_d = eff_pitch;
      line_d  = eff_line;
      done_d  = 1'b0;
      if (last) begin
        done_d = 1'b1;
      end else begin
        line_d = line_inc[LB-1:0];
        if (left_dec == '0) begin
          area_d  = next_area;
          left_d  = next_word[29:20];
          rep_d   = cfg_i.line_repeat;
          addr_d  = area_addr(next_word);
          pitch_d = area_pitch(next_word, cfg_i.control_bits[7:0]);
        end else begin
          left_d = left_dec;
          if (rep_dec == '0) begin
            rep_d  = cfg_i.line_repeat;
            addr_d = eff_addr + ADDR_BITS'(eff_pitch);
          end else begin
            rep_d = rep_dec;
          end
        end
      end
    end
  end

  assign addr_ext            = 32'(eff_addr);
  assign res_valid_o         = accept && emit;
  assign res_o.line_number   = eff_line;
  assign res_o.start_address = addr_ext[dasag_pkg::StartBits-1:0];
  assign res_o.draw_line     = !eff_line[0] || !cfg_i.control_bits[dasag_pkg::CtrlOddSkipBit];
  assign res_o.frame_last    = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_q  <= 2'd0;
      left_q  <= '0;
      rep_q   <= RB'(1);
      addr_q  <= '0;
      pitch_q <= '0;
      line_q  <= '0;
      done_q  <= 1'b1;
    end else begin
      area_q  <= area_d;
      left_q  <= left_d;
      rep_q   <= rep_d;
      addr_q  <= addr_d;
      pitch_q <= pitch_d;
      line_q  <= line_d;
      done_q  <= done_d;
    end
  end

endmodule

### rtl/dasag_skid.sv
// ---------------------------------------------------------------------------
// Display area scroll address generator output stage
// Result register backed by a one-word skid stage towards the output stream.
// ---------------------------------------------------------------------------
module dasag_skid (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  dasag_pkg::result_t in_data_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  output dasag_pkg::result_t out_data_o,
  input  logic               out_ready_i
);

  logic               out_valid_q, out_valid_d;
  logic               skid_valid_q, skid_valid_d;
  dasag_pkg::result_t out_q, out_d;
  dasag_pkg::result_t skid_q, skid_d;
  logic               out_free;

  assign in_ready_o  = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (out_free) begin
      out_valid_d  = skid_valid_q || in_valid_i;
      out_d        = skid_valid_q ? skid_q : in_data_i;
      skid_valid_d = 1'b0;
    end else if (in_valid_i) begin
      skid_valid_d = 1'b1;
      skid_d       = in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

endmodule

### bench/scan_address_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Scan address checker
// Watches the register port and both word streams of the scan address
// generator, keeps its own copy of the settings and the frame state, works
// out the line word that each accepted tick should give and compares every
// word that leaves the block with the oldest one still awaited. Register
// reads are compared with the settings written so far.
// ---------------------------------------------------------------------------
module scan_address_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel_i,
  input  logic                            penable_i,
  input  logic                            pwrite_i,
  input  logic [dasag_pkg::PaddrBits-1:0] paddr_i,
  input  logic [31:0]                     pwdata_i,
  input  logic [31:0]                     prdata_i,
  input  logic                            pready_i,
  input  logic                            tick_valid_i,
  input  logic                            tick_ready_i,
  input  logic [7:0]                      tick_data_i,
  input  logic                            line_valid_i,
  input  logic                            line_ready_i,
  input  logic [31:0]                     line_data_i,
  input  logic [0:0]                      line_user_i,
  input  logic                            line_last_i,
  output int                              fail_count_o,
  output int                              pending_o,
  output int                              predicted_o,
  output int                              checked_o
);

  logic [31:0]                      area_cfg [dasag_pkg::NumAreas];
  logic [dasag_pkg::CtrlBits-1:0]   ctrl_cfg;
  logic [dasag_pkg::RepeatBits-1:0] repeat_cfg;
  logic [dasag_pkg::LineBits-1:0]   first_cfg;
  logic [dasag_pkg::LineBits-1:0]   end_cfg;

  logic [1:0]                       area_idx;
  logic [dasag_pkg::LineBits-1:0]   lines_left;
  logic [dasag_pkg::LineBits-1:0]   cur_line;
  logic [dasag_pkg::RepeatBits-1:0] repeat_left;
  logic [dasag_pkg::StartBits-1:0]  line_addr;
  logic [dasag_pkg::PitchBits-1:0]  pitch;
  logic                             frame_over;

  dasag_pkg::result_t expected_lines [$];
  int fails;
  int predicted;
  int checked;

  task automatic flag(input string what, input logic [31:0] want, input logic [31:0] got);
    if (fails < 10) $display("MISMATCH %s: expected %0h, got %0h", what, want, got);
    fails++;
  endtask

  task automatic load_area(input logic [1:0] idx);
    logic [31:0]                     w;
    logic [dasag_pkg::PitchBits-1:0] raw;
    w = area_cfg[idx];
    raw = w[dasag_pkg::AreaPitchKeepBit] ? ctrl_cfg[dasag_pkg::PitchBits-1:0]
                                         : {ctrl_cfg[dasag_pkg::PitchBits-2:0], 1'b0};
    area_idx = idx;
    line_addr = {w[dasag_pkg::StartBits-2:0], 1'b0};
    pitch = raw & 8'hFE;
    lines_left = w[29:20];
    repeat_left = repeat_cfg;
  endtask

  task automatic predict_line(input logic restart);
    dasag_pkg::result_t res;
    logic               last;
    logic [1:0]         next_area;
    if (restart) begin
      cur_line = first_cfg;
      load_area(2'd0);
      frame_over = 1'b0;
    end
    if (!frame_over) begin
      last = ({1'b0, cur_line} + 11'd1) >= {1'b0, end_cfg};
      res.line_number = cur_line;
      res.start_address = line_addr;
      res.draw_line = !cur_line[0] || !ctrl_cfg[dasag_pkg::CtrlOddSkipBit];
      res.frame_last = last;
      expected_lines.push_back(res);
      predicted++;
      if (last) begin
        frame_over = 1'b1;
      end else begin
        cur_line = cur_line + 1'b1;
        lines_left = lines_left - 1'b1;
        if (lines_left == '0) begin
          if (ctrl_cfg[dasag_pkg::CtrlTwoAreaBit]) begin
            next_area = (area_idx == 2'd0) ? 2'd1 : 2'd0;
          end else begin
            next_area = area_idx + 2'd1;
          end
          load_area(next_area);
        end else begin
          repeat_left = repeat_left - 1'b1;
          if (repeat_left == '0) begin
            repeat_left = repeat_cfg;
            line_addr = line_addr + dasag_pkg::StartBits'(pitch);
          end
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    dasag_pkg::result_t got;
    dasag_pkg::result_t want;
    logic [31:0]        reg_val;
    if (!rst_ni) begin
      foreach (area_cfg[i]) area_cfg[i] = '0;
      ctrl_cfg = dasag_pkg::CtrlReset;
      repeat_cfg = dasag_pkg::RepeatReset;
      first_cfg = dasag_pkg::FirstLineReset;
      end_cfg = dasag_pkg::EndLineReset;
      area_idx = '0;
      lines_left = '0;
      cur_line = '0;
      repeat_left = 6'd1;
      line_addr = '0;
      pitch = '0;
      frame_over = 1'b1;
      expected_lines.delete();
      fails = 0;
      predicted = 0;
      checked = 0;
    end else begin
      if (line_valid_i && line_ready_i) begin
        got.line_number = line_data_i[dasag_pkg::LineBits-1:0];
        got.start_address =
          line_data_i[dasag_pkg::LineBits+dasag_pkg::StartBits-1:dasag_pkg::LineBits];
        got.draw_line = line_user_i[0];
        got.frame_last = line_last_i;
        if (expected_lines.size() == 0) begin
          flag("unexpected line word", '0, line_data_i);
        end else begin
          want = expected_lines.pop_front();
          checked++;
          if (got.line_number !== want.line_number)
            flag("line_number", 32'(want.line_number), 32'(got.line_number));
          if (got.start_address !== want.start_address)
            flag("start_address", 32'(want.start_address), 32'(got.start_address));
          if (got.draw_line !== want.draw_line)
            flag("draw_line", 32'(want.draw_line), 32'(got.draw_line));
          if (got.frame_last !== want.frame_last)
            flag("frame_last", 32'(want.frame_last), 32'(got.frame_last));
        end
      end

      if (psel_i && penable_i && pready_i) begin
        if (pwrite_i) begin
          case (paddr_i[dasag_pkg::PaddrBits-1:2])
            dasag_pkg::RegArea0:     area_cfg[0] = pwdata_i;
            dasag_pkg::RegArea1:     area_cfg[1] = pwdata_i;
            dasag_pkg::RegArea2:     area_cfg[2] = pwdata_i;
            dasag_pkg::RegArea3:     area_cfg[3] = pwdata_i;
            dasag_pkg::RegControl:   ctrl_cfg = pwdata_i[dasag_pkg::CtrlBits-1:0];
            dasag_pkg::RegRepeat:    repeat_cfg = pwdata_i[dasag_pkg::RepeatBits-1:0];
            dasag_pkg::RegFirstLine: first_cfg = pwdata_i[dasag_pkg::LineBits-1:0];
            dasag_pkg::RegEndLine:   end_cfg = pwdata_i[dasag_pkg::LineBits-1:0];
            default: ;
          endcase
        end else begin
          case (paddr_i[dasag_pkg::PaddrBits-1:2])
            dasag_pkg::RegArea0:     reg_val = area_cfg[0];
            dasag_pkg::RegArea1:     reg_val = area_cfg[1];
            dasag_pkg::RegArea2:     reg_val = area_cfg[2];
            dasag_pkg::RegArea3:     reg_val = area_cfg[3];
            dasag_pkg::RegControl:   reg_val = 32'(ctrl_cfg);
            dasag_pkg::RegRepeat:    reg_val = 32'(repeat_cfg);
            dasag_pkg::RegFirstLine: reg_val = 32'(first_cfg);
            default:                 reg_val = 32'(end_cfg);
          endcase
          if (prdata_i !== reg_val) flag("register read", reg_val, prdata_i);
        end
      end

      if (tick_valid_i && tick_ready_i) predict_line(tick_data_i[0]);
    end
    fail_count_o <= fails;
    pending_o <= expected_lines.size();
    predicted_o <= predicted;
    checked_o <= checked;
  end

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Scan address generator testbench
// Programs the scroll areas and frame limits over the register port, feeds
// frames of line ticks with restarts, stray ticks and cut-short frames, and
// varies the idling on both streams, including one long output stall. The
// checker beside the block predicts and compares every line word.
// ---------------------------------------------------------------------------
module tb;

  localparam int unsigned CycleLimit    = 500000;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned NumPhases     = 9;
  localparam int unsigned LinesPerPhase = 155;
  localparam int unsigned HoldCycles    = 300;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            psel = 1'b0;
  logic                            penable = 1'b0;
  logic                            pwrite = 1'b0;
  logic [dasag_pkg::PaddrBits-1:0] paddr = '0;
  logic [31:0]                     pwdata = '0;
  logic [31:0]                     prdata;
  logic                            pready;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  // Bit 0 restart, bits 7:1 zero.
  logic [7:0]                      s_axis_tdata = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  // Bits 9:0 line_number, bits 24:10 start_address, bits 31:25 zero.
  logic [31:0]                     m_axis_tdata;
  // Bit 0 draw_line.
  logic [0:0]                      m_axis_tuser;
  logic                            m_axis_tlast;

  int fail_count;
  int pending;
  int predicted;
  int checked;

  int unsigned   send_idle_pct = 36;
  int unsigned   recv_idle_pct = 85;
  int unsigned   hold_req = 0;
  int unsigned   hold_seen = 0;
  int unsigned   hold_left = 0;
  int unsigned   cycles = 0;
  int unsigned   restarts = 0;
  int unsigned   settings = 0;
  logic [31:0]   setting [8];
  logic [dasag_pkg::LineBits-1:0] first_q = dasag_pkg::FirstLineReset;
  logic [dasag_pkg::LineBits-1:0] end_q = dasag_pkg::EndLineReset;

  display_area_scroll_address_gen DUT (.*);

  scan_address_checker scan_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .prdata_i     (prdata),
    .pready_i     (pready),
    .tick_valid_i (s_axis_tvalid),
    .tick_ready_i (s_axis_tready),
    .tick_data_i  (s_axis_tdata),
    .line_valid_i (m_axis_tvalid),
    .line_ready_i (m_axis_tready),
    .line_data_i  (m_axis_tdata),
    .line_user_i  (m_axis_tuser),
    .line_last_i  (m_axis_tlast),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .predicted_o  (predicted),
    .checked_o    (checked)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles = cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HoldCycles;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic reg_access(input logic write, input logic [2:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= write;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    if (write && idx == dasag_pkg::RegFirstLine) first_q = value[dasag_pkg::LineBits-1:0];
    if (write && idx == dasag_pkg::RegEndLine) end_q = value[dasag_pkg::LineBits-1:0];
  endtask

  task automatic apb_done();
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic apply_settings();
    wait_idle();
    for (int i = dasag_pkg::RegArea0; i <= dasag_pkg::RegEndLine; i++)
      reg_access(1'b1, 3'(i), setting[i]);
    for (int i = dasag_pkg::RegArea0; i <= dasag_pkg::RegEndLine; i++)
      reg_access(1'b0, 3'(i), '0);
    apb_done();
    settings++;
  endtask

  task automatic set_register(input logic [2:0] idx, input logic [31:0] value);
    wait_idle();
    reg_access(1'b1, idx, value);
    apb_done();
    settings++;
  endtask

  task automatic push_line(input logic restart);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'd0, restart};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    if (restart) restarts++;
  endtask

  task automatic run_frame();
    int unsigned ticks;
    ticks = (end_q > first_q) ? int'(end_q - first_q) - 1 : 0;
    if ($urandom_range(99) < 10) ticks = $urandom_range(0, ticks);
    push_line(1'b1);
    repeat (ticks) push_line(1'b0);
    if ($urandom_range(99) < 10) repeat ($urandom_range(1, 3)) push_line(1'b0);
  endtask

  function automatic logic [31:0] rand_area();
    logic [31:0] w;
    int unsigned pick;
    w = $urandom();
    pick = $urandom_range(9);
    if (pick < 7) w[29:20] = 10'($urandom_range(1, 12));
    else if (pick == 7) w[29:20] = '0;
    else if (pick == 8) w[29:20] = 10'h3FF;
    return w;
  endfunction

  task automatic random_settings();
    logic [dasag_pkg::LineBits-1:0]   first_v;
    logic [dasag_pkg::LineBits-1:0]   end_v;
    logic [dasag_pkg::RepeatBits-1:0] rep_v;
    int unsigned                      k;
    for (int i = 0; i < dasag_pkg::NumAreas; i++)
      setting[dasag_pkg::RegArea0 + i] = rand_area();
    k = $urandom_range(9);
    if (k < 6) rep_v = 6'($urandom_range(1, 4));
    else if (k == 6) rep_v = 6'd0;
    else if (k == 7) rep_v = 6'd32;
    else if (k == 8) rep_v = 6'd63;
    else rep_v = 6'($urandom());
    k = $urandom_range(9);
    if (k < 5) begin
      first_v = 10'($urandom());
      end_v = (first_v > 10'd983) ? 10'd1023 : first_v + 10'($urandom_range(1, 40));
    end else if (k < 7) begin
      first_v = 10'($urandom());
      end_v = 10'($urandom_range(0, first_v));
    end else if (k < 9) begin
      end_v = 10'd1023;
      first_v = 10'd1023 - 10'($urandom_range(0, 40));
    end else begin
      first_v = '0;
      end_v = 10'($urandom_range(0, 40));
    end
    setting[dasag_pkg::RegControl] = $urandom();
    setting[dasag_pkg::RegRepeat] = {26'($urandom()), rep_v};
    setting[dasag_pkg::RegFirstLine] = {22'($urandom()), first_v};
    setting[dasag_pkg::RegEndLine] = {22'($urandom()), end_v};
    apply_settings();
  endtask

  initial begin
    int unsigned base;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // A tick with no frame running is dropped.
    push_line(1'b0);

    // Four areas with full-width start addresses; two-area mode is switched
    // on while the third area is current, then the frame is restarted.
    setting[dasag_pkg::RegArea0] = {1'b1, 1'b0, 10'd2, 4'hF, 16'hFFFF};
    setting[dasag_pkg::RegArea1] = {1'b0, 1'b1, 10'd1, 4'h0, 16'h0000};
    setting[dasag_pkg::RegArea2] = {1'b0, 1'b0, 10'd2, 4'h5, 16'h4000};
    setting[dasag_pkg::RegArea3] = {1'b1, 1'b1, 10'h3FF, 4'hA, 16'h7FFF};
    setting[dasag_pkg::RegControl] = 32'hFFFF_FDFF;
    setting[dasag_pkg::RegRepeat] = 32'hFFFF_FFC0;
    setting[dasag_pkg::RegFirstLine] = 32'h0000_0000;
    setting[dasag_pkg::RegEndLine] = 32'h0000_03FF;
    apply_settings();
    push_line(1'b1);
    repeat (3) push_line(1'b0);
    set_register(dasag_pkg::RegControl, 32'h0000_03AB);
    repeat (3) push_line(1'b0);
    push_line(1'b1);
    push_line(1'b0);

    // An area with no line count runs to the last line of the screen.
    setting[dasag_pkg::RegArea0] = {1'b0, 1'b1, 10'd0, 4'h0, 16'h1234};
    setting[dasag_pkg::RegControl] = 32'h0000_0010;
    setting[dasag_pkg::RegRepeat] = 32'd3;
    setting[dasag_pkg::RegFirstLine] = 32'd1018;
    setting[dasag_pkg::RegEndLine] = 32'd1023;
    apply_settings();
    push_line(1'b1);
    repeat (5) push_line(1'b0);

    // First line at or beyond the end line gives a one-line frame.
    set_register(dasag_pkg::RegEndLine, 32'd0);
    push_line(1'b1);
    push_line(1'b0);
    set_register(dasag_pkg::RegEndLine, 32'd1023);
    set_register(dasag_pkg::RegFirstLine, 32'd1023);
    push_line(1'b1);

    for (int p = 0; p < NumPhases; p++) begin
      if (p == 3) begin
        send_idle_pct = 85;
        recv_idle_pct = 36;
      end else if (p == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_settings();
      if (p == 6) hold_req++;
      base = predicted;
      while (predicted - base < LinesPerPhase) run_frame();
    end

    wait_idle();
    $display("Run covered %0d register settings and %0d frame restarts;", settings, restarts);
    $display("%0d line words were compared with their predictions.", checked);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/dasag_pkg.sv
rtl/dasag_regs.sv
rtl/dasag_engine.sv
rtl/dasag_skid.sv
rtl/display_area_scroll_address_gen.sv
bench/scan_address_checker.sv
bench/tb.sv
